// File: hdl/ldsc_pkg.sv
// Shared types and constants for the LED driver serial command sequencer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package ldsc_pkg;

    // Command codes on the action port
    typedef enum logic [1:0] {
        ACT_GRAY  = 2'd0,
        ACT_VSYNC = 2'd1,
        ACT_CFG1  = 2'd2,
        ACT_CFG2  = 2'd3
    } t_action;

    localparam int          WORD_W       = 16;
    localparam int          IDX_W        = 5;      // pulse index, up to 30 pulses
    localparam int          GRAY_BITS    = 14;
    localparam logic [15:0] CFG2_FORCED  = 16'h1010;
    localparam logic [4:0]  PRE_CFG      = 5'd14;  // LE-high preamble of config words
    localparam logic [4:0]  PRE_VSYNC    = 5'd3;
    localparam logic [4:0]  LAST_GRAY    = 5'd15;
    localparam logic [4:0]  LAST_VSYNC   = 5'd2;
    localparam logic [4:0]  LAST_CFG     = 5'd29;
    localparam logic [4:0]  LE_AT_GRAY   = 5'd15;
    localparam logic [4:0]  LE_AT_CFG1   = 5'd26;  // last four bits with LE high
    localparam logic [4:0]  LE_AT_CFG2   = 5'd22;  // last eight bits with LE high

    // Pulse plan of one command, handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;      // data bits, sent MSB first after the preamble
        logic [IDX_W-1:0]  pre_len;   // pulses that carry the held level with LE high
        logic [IDX_W-1:0]  le_at;     // first pulse index of the data part with LE high
        logic [IDX_W-1:0]  last_idx;  // index of the final pulse
    } t_desc;

endpackage

// File: hdl/ldsc_front.sv
// Front end: classifies an incoming command into a pulse plan.
// Depends on ldsc_pkg.
`timescale 1ns / 1ps

module ldsc_front (
    input  logic [1:0]            i_action,
    input  logic [15:0]           i_value,
    output ldsc_pkg::t_desc       o_desc
);

    ldsc_pkg::t_action action;

    always_comb begin
        action = ldsc_pkg::t_action'(i_action);
        o_desc = '0;
        case (action)
            ldsc_pkg::ACT_GRAY: begin
                // 14 bits then two zero pulses; LE on the last one
                o_desc.word     = {i_value[ldsc_pkg::GRAY_BITS-1:0], 2'b00};
                o_desc.pre_len  = '0;
                o_desc.le_at    = ldsc_pkg::LE_AT_GRAY;
                o_desc.last_idx = ldsc_pkg::LAST_GRAY;
            end
            ldsc_pkg::ACT_VSYNC: begin
                o_desc.word     = '0;
                o_desc.pre_len  = ldsc_pkg::PRE_VSYNC;
                o_desc.le_at    = ldsc_pkg::LAST_CFG;
                o_desc.last_idx = ldsc_pkg::LAST_VSYNC;
            end
            ldsc_pkg::ACT_CFG1: begin
                o_desc.word     = i_value;
                o_desc.pre_len  = ldsc_pkg::PRE_CFG;
                o_desc.le_at    = ldsc_pkg::LE_AT_CFG1;
                o_desc.last_idx = ldsc_pkg::LAST_CFG;
            end
            ldsc_pkg::ACT_CFG2: begin
                o_desc.word     = i_value | ldsc_pkg::CFG2_FORCED;
                o_desc.pre_len  = ldsc_pkg::PRE_CFG;
                o_desc.le_at    = ldsc_pkg::LE_AT_CFG2;
                o_desc.last_idx = ldsc_pkg::LAST_CFG;
            end
            default: begin
                o_desc = '0;
            end
        endcase
    end

endmodule

// File: hdl/ldsc_cmd_fifo.sv
// Two-entry queue of pulse plans between front and back.
// Depends on ldsc_pkg.
`timescale 1ns / 1ps

module ldsc_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  ldsc_pkg::t_desc  i_wr_desc,
    output logic             o_full,
    input  logic             i_rd,
    output ldsc_pkg::t_desc  o_rd_desc,
    output logic             o_valid
);

    ldsc_pkg::t_desc r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_rd_desc = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_mem[r_wr_ptr] <= i_wr_desc;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/ldsc_back.sv
// Back end: plays out one pulse plan per command, one pulse per cycle unless stalled,
// into an output register. Keeps the held data level. Depends on ldsc_pkg.
`timescale 1ns / 1ps

module ldsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ldsc_pkg::t_desc  i_desc,
    output logic             o_take,
    output logic             o_empty,
    input  logic             i_pop,
    output logic             o_sdi,
    output logic             o_le,
    output logic             o_last
);

    ldsc_pkg::t_desc                   r_desc;
    logic [ldsc_pkg::WORD_W-1:0]       r_shift;
    logic [ldsc_pkg::IDX_W-1:0]        r_idx;
    logic                              r_busy;
    logic                              r_held;
    logic                              r_out_valid;

    logic cur_pre;
    logic pulse_sdi;
    logic pulse_le;
    logic pulse_last;
    logic emit;

    always_comb begin
        cur_pre    = (r_idx < r_desc.pre_len);
        pulse_sdi  = cur_pre ? r_held : r_shift[ldsc_pkg::WORD_W-1];
        pulse_le   = cur_pre ? 1'b1 : (r_idx >= r_desc.le_at);
        pulse_last = (r_idx == r_desc.last_idx);
        emit       = r_busy && (!r_out_valid || i_pop);
        o_take     = i_valid && (!r_busy || (emit && pulse_last));
    end

    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_sdi  <= pulse_sdi;
                o_le   <= pulse_le;
                o_last <= pulse_last;
                r_held <= pulse_sdi;
            end
            // a new plan replaces the finished one in the cycle of its last pulse
            if (o_take) begin
                r_desc  <= i_desc;
                r_shift <= i_desc.word;
                r_idx   <= '0;
                r_busy  <= 1'b1;
            end else begin
                if (emit) begin
                    r_idx <= r_idx + ldsc_pkg::IDX_W'(1);
                    if (!cur_pre) begin
                        r_shift <= {r_shift[ldsc_pkg::WORD_W-2:0], 1'b0};
                    end
                end
                if (emit && pulse_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/led_driver_serial_command_sequencer_unit.sv
// Top level of the LED driver serial command sequencer (data/clock/latch serial link).
// Depends on ldsc_pkg, ldsc_front, ldsc_cmd_fifo and ldsc_back.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+------------------------------
//  command  | in        | push / full          | i_action[1:0], i_value[15:0]
//  pulse    | out       | empty / pop          | o_sdi, o_le, o_last
//
// Each command yields one pulse word per cycle unless stalled: 16 for grayscale,
// 3 for vsync, 30 for either config word. The back sequencer is the limit; a queued
// next command loads with the previous last pulse and, unstalled, follows it directly.
// A two-entry queue lets commands be pushed while an earlier one still plays out.
// Reset (synchronous, active low) empties the queue and output register and
// clears the held data level. A stalled pulse holds in the output register.

module led_driver_serial_command_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic        o_sdi,
    output logic        o_le,
    output logic        o_last
);

    ldsc_pkg::t_desc front_desc;
    ldsc_pkg::t_desc queue_desc;
    logic            queue_valid;
    logic            back_take;

    // Classify the command into a pulse plan
    ldsc_front u_front (
        .i_action (i_action),
        .i_value  (i_value),
        .o_desc   (front_desc)
    );

    // Hold plans until the back end is free
    ldsc_cmd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push && !full),
        .i_wr_desc (front_desc),
        .o_full    (full),
        .i_rd      (back_take),
        .o_rd_desc (queue_desc),
        .o_valid   (queue_valid)
    );

    // Advance through the pulses of the current plan
    ldsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_desc  (queue_desc),
        .o_take  (back_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_sdi   (o_sdi),
        .o_le    (o_le),
        .o_last  (o_last)
    );

endmodule
